/* hw/rtl/hss_pkg.sv */
`timescale 1ns / 1ps

package hss_pkg;

   localparam int DATA_W       = 32;
   localparam int MAG_W        = 31;
   localparam int ANGLE_W      = 16;
   localparam int TRIG_W       = 16;
   localparam int COUNT_W      = 7;
   localparam int INDEX_W      = 6;
   localparam int MAX_SAMPLES  = 64;
   localparam int MIN_SAMPLES  = 3;
   localparam int SINE_ENTRIES = 256;
   localparam int SINE_IDX_W   = $clog2(SINE_ENTRIES);
   localparam int QTR_SHIFT    = 14;
   localparam int QUARTER_TURN = 1 << QTR_SHIFT;
   localparam int LOOK_W       = QTR_SHIFT + 2 + SINE_IDX_W;
   localparam int TRIG_MAX     = 32767;
   localparam int QUEUE_DEPTH  = 2;

   // Widths of the point arithmetic. D is at most 63, so D^3 fits in 18 bits.
   localparam int D2_W   = 2 * INDEX_W;
   localparam int D3_W   = 18;
   localparam int COEF_W = 21;
   localparam int PROD_W = DATA_W + COEF_W;
   localparam int ACC_W  = PROD_W + 1;
   localparam int QUO_W  = 34;

   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint TAYLOR_DIV [8] = '{6, 20, 42, 72, 110, 156, 210, 272};

   typedef logic [TRIG_W-1:0] sine_table_type [SINE_ENTRIES];

   typedef struct packed {
      logic signed [DATA_W-1:0] p0x;
      logic signed [DATA_W-1:0] p0y;
      logic signed [DATA_W-1:0] p1x;
      logic signed [DATA_W-1:0] p1y;
      logic signed [DATA_W-1:0] r0x;
      logic signed [DATA_W-1:0] r0y;
      logic signed [DATA_W-1:0] r1x;
      logic signed [DATA_W-1:0] r1y;
   } seg_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_LOOK,
      F_MUL,
      F_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_D2,
      B_D3,
      B_K1,
      B_K2,
      B_K3,
      B_MAC,
      B_DVS,
      B_DIV,
      B_OUT
   } back_state_type;

   // Quarter-wave sine in Q1.15 from a Q2.30 Taylor series, evaluated at elaboration.
   function automatic sine_table_type build_sine_table();
      sine_table_type tab;
      longint th;
      longint th2;
      longint term;
      longint sum;
      longint r;
      int i;
      int n;
      for (i = 0; i < SINE_ENTRIES; i++) begin
         th   = (longint'(i) * HALF_PI_Q30) / SINE_ENTRIES;
         th2  = (th * th) >>> 30;
         term = th;
         sum  = th;
         for (n = 1; n <= 8; n++) begin
            term = (term * th2) >>> 30;
            term = term / TAYLOR_DIV[n-1];
            if ((n & 1) != 0) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         r = (sum + (longint'(1) <<< 14)) >>> 15;
         if (r > TRIG_MAX) begin
            r = TRIG_MAX;
         end
         tab[i] = TRIG_W'(r);
      end
      return tab;
   endfunction

   localparam sine_table_type SINE_TABLE = build_sine_table();

   function automatic logic signed [TRIG_W-1:0] quarter_sine(logic [QTR_SHIFT:0] p);
      logic [LOOK_W-1:0] idx;
      idx = (LOOK_W'(p) * LOOK_W'(SINE_ENTRIES) + LOOK_W'(QUARTER_TURN / 2)) >> QTR_SHIFT;
      if (idx >= LOOK_W'(SINE_ENTRIES)) begin
         return TRIG_W'(TRIG_MAX);
      end
      return signed'(SINE_TABLE[idx[SINE_IDX_W-1:0]]);
   endfunction

   function automatic logic signed [TRIG_W-1:0] sine_q15(logic [ANGLE_W-1:0] a);
      logic [QTR_SHIFT:0] p;
      logic signed [TRIG_W-1:0] v;
      if (a[QTR_SHIFT]) begin
         p = (QTR_SHIFT+1)'(QUARTER_TURN) - {1'b0, a[QTR_SHIFT-1:0]};
      end else begin
         p = {1'b0, a[QTR_SHIFT-1:0]};
      end
      v = quarter_sine(p);
      return a[QTR_SHIFT+1] ? -v : v;
   endfunction

endpackage

/* hw/rtl/hss_front.sv */
`timescale 1ns / 1ps

module hss_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [hss_pkg::DATA_W-1:0]  req_start_x,
   input  logic signed [hss_pkg::DATA_W-1:0]  req_start_y,
   input  logic signed [hss_pkg::DATA_W-1:0]  req_end_x,
   input  logic signed [hss_pkg::DATA_W-1:0]  req_end_y,
   input  logic [hss_pkg::ANGLE_W-1:0]   req_start_angle,
   input  logic [hss_pkg::MAG_W-1:0]     req_start_magnitude,
   input  logic [hss_pkg::ANGLE_W-1:0]   req_end_angle,
   input  logic [hss_pkg::MAG_W-1:0]     req_end_magnitude,
   output logic                          push_valid,
   input  logic                          push_ready,
   output hss_pkg::seg_type              push_data
);
   import hss_pkg::*;

   localparam int TM_W = TRIG_W - 1;
   localparam int PM_W = MAG_W + TM_W;

   front_state_type state_ff, state_in;

   logic signed [DATA_W-1:0] p0x_ff, p0y_ff, p1x_ff, p1y_ff;
   logic [ANGLE_W-1:0]       a0_ff, a1_ff;
   logic [MAG_W-1:0]         m0_ff, m1_ff;
   // Trig values in order: cos0, sin0, cos1, sin1.
   logic signed [TRIG_W-1:0] trig_ff [4];
   logic signed [TRIG_W-1:0] trig_in [4];
   logic [PM_W-1:0]          prod_ff [4];
   logic [PM_W-1:0]          prod_in [4];
   logic                     neg_ff  [4];
   logic signed [DATA_W-1:0] tan_val [4];
   logic [PM_W:0]            rnd     [4];
   logic [TM_W-1:0]          tmag    [4];
   logic                     accept;

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      push_valid = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = F_LOOK;
            end
         end
         F_LOOK: state_in = F_MUL;
         F_MUL:  state_in = F_PUSH;
         F_PUSH: begin
            push_valid = 1'b1;
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_comb begin
      trig_in[0] = sine_q15(a0_ff + ANGLE_W'(QUARTER_TURN));
      trig_in[1] = sine_q15(a0_ff);
      trig_in[2] = sine_q15(a1_ff + ANGLE_W'(QUARTER_TURN));
      trig_in[3] = sine_q15(a1_ff);
      for (int i = 0; i < 4; i++) begin
         tmag[i]    = trig_ff[i][TRIG_W-1] ? TM_W'(-trig_ff[i]) : trig_ff[i][TM_W-1:0];
         prod_in[i] = PM_W'((i < 2) ? m0_ff : m1_ff) * PM_W'(tmag[i]);
         // Rounded half away from zero: round the magnitude, then restore the sign.
         rnd[i]     = {1'b0, prod_ff[i]} + (PM_W+1)'(1 << (TM_W - 1));
         tan_val[i] = neg_ff[i] ? -{1'b0, rnd[i][PM_W-1:TM_W]} : {1'b0, rnd[i][PM_W-1:TM_W]};
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p0x_ff <= req_start_x;
         p0y_ff <= req_start_y;
         p1x_ff <= req_end_x;
         p1y_ff <= req_end_y;
         a0_ff  <= req_start_angle;
         a1_ff  <= req_end_angle;
         m0_ff  <= req_start_magnitude;
         m1_ff  <= req_end_magnitude;
      end
      if (state_ff == F_LOOK) begin
         trig_ff <= trig_in;
      end
      if (state_ff == F_MUL) begin
         prod_ff <= prod_in;
         for (int i = 0; i < 4; i++) begin
            neg_ff[i] <= trig_ff[i][TRIG_W-1];
         end
      end
   end

   always_comb begin
      push_data.p0x = p0x_ff;
      push_data.p0y = p0y_ff;
      push_data.p1x = p1x_ff;
      push_data.p1y = p1y_ff;
      push_data.r0x = tan_val[0];
      push_data.r0y = tan_val[1];
      push_data.r1x = tan_val[2];
      push_data.r1y = tan_val[3];
   end

endmodule

/* hw/rtl/hss_queue.sv */
`timescale 1ns / 1ps

module hss_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  hss_pkg::seg_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output hss_pkg::seg_type pop_data
);
   import hss_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   seg_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hw/rtl/hss_back.sv */
`timescale 1ns / 1ps

module hss_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [hss_pkg::INDEX_W-1:0]       span,
   input  logic                              pop_valid,
   output logic                              pop_ready,
   input  hss_pkg::seg_type                  pop_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [hss_pkg::DATA_W-1:0] rsp_point_x,
   output logic signed [hss_pkg::DATA_W-1:0] rsp_point_y,
   output logic [hss_pkg::INDEX_W-1:0]       rsp_sample_index,
   output logic                              rsp_last_point
);
   import hss_pkg::*;

   localparam int DVD_W = ACC_W;
   localparam int CNT_W = $clog2(QUO_W);

   back_state_type state_ff, state_in;

   seg_type                  seg_ff;
   logic [INDEX_W-1:0]       d_ff, k_ff;
   logic [D2_W-1:0]          d2_ff, k2_ff, kd_ff;
   logic [D3_W-1:0]          d3_ff, k3_ff, k2d_ff, kd2_ff;
   logic signed [COEF_W-1:0] h_ff [4];
   logic signed [COEF_W-1:0] h_in [4];
   logic [CNT_W-1:0]         cnt_ff;
   logic signed [PROD_W-1:0] prodx_ff, prody_ff, prodx_in, prody_in;
   logic signed [ACC_W-1:0]  accx_ff, accy_ff, accx_in, accy_in;
   logic                     negx_ff, negy_ff;
   logic [D3_W-1:0]          remx_ff, remy_ff, remx_in, remy_in;
   logic [QUO_W-1:0]         quox_ff, quoy_ff, quox_in, quoy_in;
   logic [DVD_W-1:0]         dvdx, dvdy;
   logic [D3_W:0]            trialx, trialy;
   logic signed [DATA_W-1:0] macx_a, macy_a;
   logic signed [COEF_W-1:0] mac_h, t3, t2d, td2, td3;
   logic signed [DATA_W-1:0] satx, saty;
   logic                     out_load, last_k;

   assign last_k = (k_ff == d_ff - 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      pop_ready = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               state_in = B_D2;
            end
         end
         B_D2: state_in = B_D3;
         B_D3: state_in = B_K1;
         B_K1: state_in = B_K2;
         B_K2: state_in = B_K3;
         B_K3: state_in = B_MAC;
         B_MAC: begin
            if (cnt_ff == CNT_W'(4)) begin
               state_in = B_DVS;
            end
         end
         B_DVS: state_in = B_DIV;
         B_DIV: begin
            if (cnt_ff == CNT_W'(QUO_W - 1)) begin
               state_in = B_OUT;
            end
         end
         B_OUT: begin
            // The output register frees up in the same cycle its transfer completes.
            if (!rsp_valid || rsp_ready) begin
               out_load = 1'b1;
               state_in = last_k ? B_IDLE : B_K1;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   // Hermite basis weights scaled by D^3.
   always_comb begin
      t3  = COEF_W'(k3_ff);
      t2d = COEF_W'(k2d_ff);
      td2 = COEF_W'(kd2_ff);
      td3 = COEF_W'(d3_ff);
      h_in[0] = (t3 <<< 1) - (t2d + (t2d <<< 1)) + td3;
      h_in[1] = t3 - (t2d <<< 1) + td2;
      h_in[2] = (t2d + (t2d <<< 1)) - (t3 <<< 1);
      h_in[3] = t3 - t2d;
   end

   always_comb begin
      unique case (cnt_ff[1:0])
         2'd0: begin macx_a = seg_ff.p0x; macy_a = seg_ff.p0y; end
         2'd1: begin macx_a = seg_ff.r0x; macy_a = seg_ff.r0y; end
         2'd2: begin macx_a = seg_ff.p1x; macy_a = seg_ff.p1y; end
         default: begin macx_a = seg_ff.r1x; macy_a = seg_ff.r1y; end
      endcase
      mac_h    = h_ff[cnt_ff[1:0]];
      prodx_in = PROD_W'(macx_a) * PROD_W'(mac_h);
      prody_in = PROD_W'(macy_a) * PROD_W'(mac_h);
      if (cnt_ff == '0) begin
         accx_in = '0;
         accy_in = '0;
      end else begin
         accx_in = accx_ff + {prodx_ff[PROD_W-1], prodx_ff};
         accy_in = accy_ff + {prody_ff[PROD_W-1], prody_ff};
      end
   end

   // Round half away from zero on the magnitude, then divide restoring style.
   always_comb begin
      dvdx = (accx_ff[ACC_W-1] ? DVD_W'(-accx_ff) : DVD_W'(accx_ff)) + DVD_W'(d3_ff >> 1);
      dvdy = (accy_ff[ACC_W-1] ? DVD_W'(-accy_ff) : DVD_W'(accy_ff)) + DVD_W'(d3_ff >> 1);
      trialx = {remx_ff, quox_ff[QUO_W-1]};
      trialy = {remy_ff, quoy_ff[QUO_W-1]};
      if (state_ff == B_DVS) begin
         remx_in = dvdx[QUO_W +: D3_W];
         remy_in = dvdy[QUO_W +: D3_W];
         quox_in = dvdx[QUO_W-1:0];
         quoy_in = dvdy[QUO_W-1:0];
      end else begin
         if (trialx >= {1'b0, d3_ff}) begin
            remx_in = D3_W'(trialx - {1'b0, d3_ff});
            quox_in = {quox_ff[QUO_W-2:0], 1'b1};
         end else begin
            remx_in = trialx[D3_W-1:0];
            quox_in = {quox_ff[QUO_W-2:0], 1'b0};
         end
         if (trialy >= {1'b0, d3_ff}) begin
            remy_in = D3_W'(trialy - {1'b0, d3_ff});
            quoy_in = {quoy_ff[QUO_W-2:0], 1'b1};
         end else begin
            remy_in = trialy[D3_W-1:0];
            quoy_in = {quoy_ff[QUO_W-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      if (!negx_ff) begin
         satx = (quox_ff > QUO_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : signed'(quox_ff[DATA_W-1:0]);
      end else begin
         satx = (quox_ff > QUO_W'(32'h8000_0000)) ? 32'sh8000_0000 : -signed'(quox_ff[DATA_W-1:0]);
      end
      if (!negy_ff) begin
         saty = (quoy_ff > QUO_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : signed'(quoy_ff[DATA_W-1:0]);
      end else begin
         saty = (quoy_ff > QUO_W'(32'h8000_0000)) ? 32'sh8000_0000 : -signed'(quoy_ff[DATA_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (out_load) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (state_ff == B_MAC || state_ff == B_DIV) begin
         cnt_ff <= (state_in == state_ff) ? cnt_ff + 1'b1 : '0;
      end else begin
         cnt_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         B_IDLE: begin
            seg_ff <= pop_data;
            d_ff   <= span;
         end
         B_D2: d2_ff <= D2_W'(d_ff) * D2_W'(d_ff);
         B_D3: begin
            d3_ff <= D3_W'(d2_ff) * D3_W'(d_ff);
            k_ff  <= INDEX_W'(1);
         end
         B_K1: begin
            k2_ff <= D2_W'(k_ff) * D2_W'(k_ff);
            kd_ff <= D2_W'(k_ff) * D2_W'(d_ff);
         end
         B_K2: begin
            k3_ff  <= D3_W'(k2_ff) * D3_W'(k_ff);
            k2d_ff <= D3_W'(k2_ff) * D3_W'(d_ff);
            kd2_ff <= D3_W'(kd_ff) * D3_W'(d_ff);
         end
         B_K3: h_ff <= h_in;
         B_MAC: begin
            prodx_ff <= prodx_in;
            prody_ff <= prody_in;
            accx_ff  <= accx_in;
            accy_ff  <= accy_in;
         end
         B_DVS: begin
            negx_ff <= accx_ff[ACC_W-1];
            negy_ff <= accy_ff[ACC_W-1];
            remx_ff <= remx_in;
            remy_ff <= remy_in;
            quox_ff <= quox_in;
            quoy_ff <= quoy_in;
         end
         B_DIV: begin
            remx_ff <= remx_in;
            remy_ff <= remy_in;
            quox_ff <= quox_in;
            quoy_ff <= quoy_in;
         end
         B_OUT: begin
            if (out_load) begin
               rsp_point_x      <= satx;
               rsp_point_y      <= saty;
               rsp_sample_index <= k_ff;
               rsp_last_point   <= last_k;
               k_ff             <= k_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DIV) |-> (cnt_ff < CNT_W'(QUO_W)))
      else $error("divider step count overran");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DIV) |-> (remx_ff < d3_ff && remy_ff < d3_ff))
      else $error("partial remainder not below divisor");

   a_k_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_OUT) |-> (k_ff != '0 && k_ff < d_ff))
      else $error("sample index outside the segment");

endmodule

/* hw/rtl/hermite_segment_sampler_top.sv */
`timescale 1ns / 1ps
// A segment passes through the front end (table lookup, multiply, push) and the queue; the
// back end then computes D^2 and D^3 and, for each interior point, the weights, a multiply-
// accumulate and a 34-step serial divider before the point is loaded into the output register.
// The back end takes a new segment only after the last point of the previous one is loaded.
// A two-entry queue lets the front end take further segments while points are produced.
// Reset (synchronous, active high) empties the queue, idles both ends, sets sample_count to 3.

module hermite_segment_sampler_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [hss_pkg::COUNT_W-1:0]       csr_wr_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [hss_pkg::DATA_W-1:0] req_start_x,
   input  logic signed [hss_pkg::DATA_W-1:0] req_start_y,
   input  logic signed [hss_pkg::DATA_W-1:0] req_end_x,
   input  logic signed [hss_pkg::DATA_W-1:0] req_end_y,
   input  logic [hss_pkg::ANGLE_W-1:0]       req_start_angle,
   input  logic [hss_pkg::MAG_W-1:0]         req_start_magnitude,
   input  logic [hss_pkg::ANGLE_W-1:0]       req_end_angle,
   input  logic [hss_pkg::MAG_W-1:0]         req_end_magnitude,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [hss_pkg::DATA_W-1:0] rsp_point_x,
   output logic signed [hss_pkg::DATA_W-1:0] rsp_point_y,
   output logic [hss_pkg::INDEX_W-1:0]       rsp_sample_index,
   output logic                              rsp_last_point
);
   import hss_pkg::*;

   logic [COUNT_W-1:0] sample_count_ff;
   logic [COUNT_W-1:0] n_clamped;
   logic [INDEX_W-1:0] span;
   logic               push_valid, push_ready, pop_valid, pop_ready;
   seg_type            push_data, pop_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= COUNT_W'(MIN_SAMPLES);
      end else if (csr_wr_en) begin
         sample_count_ff <= csr_wr_data;
      end
   end

   always_comb begin
      priority if (sample_count_ff < COUNT_W'(MIN_SAMPLES)) begin
         n_clamped = COUNT_W'(MIN_SAMPLES);
      end else if (sample_count_ff > COUNT_W'(MAX_SAMPLES)) begin
         n_clamped = COUNT_W'(MAX_SAMPLES);
      end else begin
         n_clamped = sample_count_ff;
      end
      span = INDEX_W'(n_clamped - 1'b1);
   end

   hss_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_start_x         (req_start_x),
      .req_start_y         (req_start_y),
      .req_end_x           (req_end_x),
      .req_end_y           (req_end_y),
      .req_start_angle     (req_start_angle),
      .req_start_magnitude (req_start_magnitude),
      .req_end_angle       (req_end_angle),
      .req_end_magnitude   (req_end_magnitude),
      .push_valid          (push_valid),
      .push_ready          (push_ready),
      .push_data           (push_data)
   );

   hss_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   hss_back u_back (
      .clock            (clock),
      .reset            (reset),
      .span             (span),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_data         (pop_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_point_x      (rsp_point_x),
      .rsp_point_y      (rsp_point_y),
      .rsp_sample_index (rsp_sample_index),
      .rsp_last_point   (rsp_last_point)
   );

endmodule

/* tb/tb_hermite_segment_sampler_top.sv */
`timescale 1ns / 1ps

module tb_hermite_segment_sampler_top;
   import hss_pkg::*;

   localparam longint CYCLE_LIMIT = 10000000;
   localparam int DRAIN_CYCLES = 120;

   typedef struct {
      logic signed [DATA_W-1:0] sx;
      logic signed [DATA_W-1:0] sy;
      logic signed [DATA_W-1:0] ex;
      logic signed [DATA_W-1:0] ey;
      logic [ANGLE_W-1:0]       sa;
      logic [MAG_W-1:0]         sm;
      logic [ANGLE_W-1:0]       ea;
      logic [MAG_W-1:0]         em;
   } segment_type;

   typedef struct {
      logic signed [DATA_W-1:0] px;
      logic signed [DATA_W-1:0] py;
      logic [INDEX_W-1:0]       idx;
      logic                     last;
   } point_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_wr_en = 1'b0;
   logic [COUNT_W-1:0]         csr_wr_data = '0;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [DATA_W-1:0]   req_start_x = '0;
   logic signed [DATA_W-1:0]   req_start_y = '0;
   logic signed [DATA_W-1:0]   req_end_x = '0;
   logic signed [DATA_W-1:0]   req_end_y = '0;
   logic [ANGLE_W-1:0]         req_start_angle = '0;
   logic [MAG_W-1:0]           req_start_magnitude = '0;
   logic [ANGLE_W-1:0]         req_end_angle = '0;
   logic [MAG_W-1:0]           req_end_magnitude = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [DATA_W-1:0]   rsp_point_x;
   logic signed [DATA_W-1:0]   rsp_point_y;
   logic [INDEX_W-1:0]         rsp_sample_index;
   logic                       rsp_last_point;

   int        sine_lut [SINE_ENTRIES];
   logic [COUNT_W-1:0] sample_count_shadow = COUNT_W'(MIN_SAMPLES);
   point_type pending_points [$];
   int        fail_count = 0;
   int        segments_sent = 0;
   int        points_checked = 0;
   int        csr_writes = 0;
   longint    cycle_count = 0;
   bit        tx_idle = 1'b1;
   bit        rx_idle = 1'b1;
   int        rx_stall = 0;
   int        rx_hold = 0;

   hermite_segment_sampler_top dut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_start_x(req_start_x),
      .req_start_y(req_start_y),
      .req_end_x(req_end_x),
      .req_end_y(req_end_y),
      .req_start_angle(req_start_angle),
      .req_start_magnitude(req_start_magnitude),
      .req_end_angle(req_end_angle),
      .req_end_magnitude(req_end_magnitude),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_point_x(rsp_point_x),
      .rsp_point_y(rsp_point_y),
      .rsp_sample_index(rsp_sample_index),
      .rsp_last_point(rsp_last_point)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles.", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Quarter-wave sine in Q1.15 from a Q2.30 Taylor series.
   function automatic void fill_sine_lut();
      longint th;
      longint th2;
      longint term;
      longint acc;
      longint r;
      for (int i = 0; i < SINE_ENTRIES; i++) begin
         th = (longint'(i) * 64'sd1686629713) / SINE_ENTRIES;
         th2 = (th * th) >>> 30;
         term = th;
         acc = th;
         for (int n = 1; n <= 8; n++) begin
            term = (term * th2) >>> 30;
            term = term / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
               acc = acc - term;
            end else begin
               acc = acc + term;
            end
         end
         if (acc < 0) begin
            acc = 0;
         end
         r = (acc + 64'sd16384) >>> 15;
         if (r > 32767) begin
            r = 32767;
         end
         sine_lut[i] = int'(r);
      end
   endfunction

   function automatic int quarter_wave(int p);
      int slot;
      slot = (p * SINE_ENTRIES + 8192) / 16384;
      if (slot >= SINE_ENTRIES) begin
         return 32767;
      end
      return sine_lut[slot];
   endfunction

   function automatic int sine_of(logic [ANGLE_W-1:0] a);
      int v;
      int rem;
      rem = int'(a[13:0]);
      v = a[14] ? quarter_wave(16384 - rem) : quarter_wave(rem);
      return a[15] ? -v : v;
   endfunction

   function automatic longint div_round(longint num, longint den);
      if (num >= 0) begin
         return (num + den / 2) / den;
      end
      return -((-num + den / 2) / den);
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) begin
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // Appends every interior point of one segment to the pending list.
   task automatic predict_points(segment_type s);
      longint r0x;
      longint r0y;
      longint r1x;
      longint r1y;
      longint d;
      longint d3;
      longint k2;
      longint k3;
      longint h00;
      longint h10;
      longint h01;
      longint h11;
      longint nx;
      longint ny;
      int     n;
      point_type p;
      n = int'(sample_count_shadow);
      if (n < MIN_SAMPLES) begin
         n = MIN_SAMPLES;
      end
      if (n > MAX_SAMPLES) begin
         n = MAX_SAMPLES;
      end
      r0x = div_round(longint'(s.sm) * sine_of(s.sa + 16'd16384), 32768);
      r0y = div_round(longint'(s.sm) * sine_of(s.sa), 32768);
      r1x = div_round(longint'(s.em) * sine_of(s.ea + 16'd16384), 32768);
      r1y = div_round(longint'(s.em) * sine_of(s.ea), 32768);
      d = n - 1;
      d3 = d * d * d;
      for (longint k = 1; k <= n - 2; k++) begin
         k2 = k * k;
         k3 = k2 * k;
         h00 = 2 * k3 - 3 * k2 * d + d3;
         h10 = k3 - 2 * k2 * d + k * d * d;
         h01 = -2 * k3 + 3 * k2 * d;
         h11 = k3 - k2 * d;
         nx = longint'(s.sx) * h00 + r0x * h10 + longint'(s.ex) * h01 + r1x * h11;
         ny = longint'(s.sy) * h00 + r0y * h10 + longint'(s.ey) * h01 + r1y * h11;
         p.px = DATA_W'(clamp32(div_round(nx, d3)));
         p.py = DATA_W'(clamp32(div_round(ny, d3)));
         p.idx = INDEX_W'(k);
         p.last = (k == n - 2);
         pending_points.insert(pending_points.size(), p);
      end
   endtask

   // Receiver: a fresh stall is drawn after every transfer while rx_idle is set; a hold-off overrides it.
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         rx_stall = rx_idle ? $urandom_range(0, 9) : 0;
      end else if (rx_stall > 0) begin
         rx_stall = rx_stall - 1;
      end
      if (rx_hold > 0) begin
         rx_hold = rx_hold - 1;
      end
      rsp_ready <= !reset && rx_stall == 0 && rx_hold == 0;
   end

   always @(posedge clock) begin
      point_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_points.size() == 0) begin
            $error("Point transfer with nothing pending: x=%0d y=%0d k=%0d",
                   rsp_point_x, rsp_point_y, rsp_sample_index);
            fail_count++;
         end else begin
            want = pending_points.pop_front();
            points_checked++;
            if (rsp_point_x !== want.px) begin
               $error("point_x: expected %0d, got %0d", want.px, rsp_point_x);
               fail_count++;
            end
            if (rsp_point_y !== want.py) begin
               $error("point_y: expected %0d, got %0d", want.py, rsp_point_y);
               fail_count++;
            end
            if (rsp_sample_index !== want.idx) begin
               $error("sample_index: expected %0d, got %0d", want.idx, rsp_sample_index);
               fail_count++;
            end
            if (rsp_last_point !== want.last) begin
               $error("last_point: expected %0d, got %0d", want.last, rsp_last_point);
               fail_count++;
            end
         end
      end
   end

   task automatic send_segment(segment_type s);
      int gap;
      gap = tx_idle ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_start_x <= s.sx;
      req_start_y <= s.sy;
      req_end_x <= s.ex;
      req_end_y <= s.ey;
      req_start_angle <= s.sa;
      req_start_magnitude <= s.sm;
      req_end_angle <= s.ea;
      req_end_magnitude <= s.em;
      do @(posedge clock); while (!req_ready);
      predict_points(s);
      segments_sent++;
   endtask

   // Drops valid and waits until every pending point has come back.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_sample_count(logic [COUNT_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sample_count_shadow = value;
      csr_writes++;
   endtask

   function automatic logic signed [DATA_W-1:0] pick_coord();
      case ($urandom_range(0, 4))
         0: return $urandom_range(0, 1 << 21) - (1 << 20);
         1: return $urandom_range(0, 1 << 25) - (1 << 24);
         2: begin
            case ($urandom_range(0, 3))
               0: return 32'sh7FFFFFFF;
               1: return 32'sh80000000;
               2: return 0;
               default: return -1;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [MAG_W-1:0] pick_magnitude();
      case ($urandom_range(0, 4))
         0: return MAG_W'($urandom_range(0, 1 << 20));
         1: return $urandom_range(0, 1) ? '1 : '0;
         2: return MAG_W'($urandom_range(0, 1 << 24));
         default: return MAG_W'($urandom);
      endcase
   endfunction

   function automatic logic [ANGLE_W-1:0] pick_angle();
      if ($urandom_range(0, 4) == 0) begin
         return ANGLE_W'($urandom_range(0, 3) * 16384 + $urandom_range(0, 2) - 1);
      end
      return ANGLE_W'($urandom);
   endfunction

   function automatic segment_type random_segment();
      segment_type s;
      s.sx = pick_coord();
      s.sy = pick_coord();
      s.ex = pick_coord();
      s.ey = pick_coord();
      s.sa = pick_angle();
      s.sm = pick_magnitude();
      s.ea = pick_angle();
      s.em = pick_magnitude();
      return s;
   endfunction

   function automatic segment_type uniform_segment(logic signed [DATA_W-1:0] c,
                                                   logic [ANGLE_W-1:0] a,
                                                   logic [MAG_W-1:0] m);
      segment_type s;
      s.sx = c;
      s.sy = c;
      s.ex = c;
      s.ey = c;
      s.sa = a;
      s.sm = m;
      s.ea = a;
      s.em = m;
      return s;
   endfunction

   // The register is left at its reset value of three: one point per segment.
   task automatic test_reset_count();
      send_segment(uniform_segment(0, 0, 0));
      send_segment(random_segment());
      wait_idle();
   endtask

   task automatic test_field_extremes();
      segment_type s;
      write_sample_count(7'd6);
      send_segment(uniform_segment(32'sh7FFFFFFF, 16'hFFFF, '1));
      send_segment(uniform_segment(32'sh80000000, 16'h0000, '1));
      s = uniform_segment(32'sh7FFFFFFF, 16'h2000, '1);
      s.ex = 32'sh80000000;
      s.ey = 32'sh80000000;
      s.ea = 16'hA000;
      send_segment(s);
      send_segment(uniform_segment(-1, 16'h8000, 31'd65536));
      wait_idle();
   endtask

   // Quadrant boundaries and their neighbors exercise the table fold.
   task automatic test_angles();
      segment_type s;
      logic [ANGLE_W-1:0] marks [8] = '{16'h0000, 16'h3FFF, 16'h4000, 16'h4001,
                                       16'h8000, 16'hBFFF, 16'hC000, 16'h2000};
      write_sample_count(7'd4);
      foreach (marks[i]) begin
         s = uniform_segment(0, marks[i], 31'h00010000);
         s.ex = 32'sh00010000;
         s.ea = ~marks[i];
         send_segment(s);
      end
      wait_idle();
   endtask

   task automatic test_count_limits();
      logic [COUNT_W-1:0] counts [6] = '{7'd0, 7'd1, 7'd2, 7'd64, 7'd127, 7'd65};
      foreach (counts[i]) begin
         write_sample_count(counts[i]);
         send_segment(random_segment());
         wait_idle();
      end
   endtask

   // The receiver stops long enough for the queue to fill and stall the input.
   task automatic test_output_hold_off();
      write_sample_count(7'd5);
      tx_idle = 1'b0;
      rx_hold = 600;
      repeat (8) send_segment(random_segment());
      tx_idle = 1'b1;
      wait_idle();
   endtask

   task automatic test_random_segments(int total);
      logic [COUNT_W-1:0] n;
      int block;
      int sent;
      sent = 0;
      while (sent < total) begin
         case ($urandom_range(0, 19))
            0: n = COUNT_W'($urandom_range(0, 2));
            1: n = COUNT_W'($urandom_range(40, 127));
            2: n = 7'd64;
            default: n = COUNT_W'($urandom_range(3, 10));
         endcase
         tx_idle = $urandom_range(0, 3) != 0;
         rx_idle = $urandom_range(0, 3) != 0;
         write_sample_count(n);
         block = (n > 20) ? 3 : $urandom_range(10, 40);
         repeat (block) send_segment(random_segment());
         sent += block;
         wait_idle();
      end
      rx_idle = 1'b1;
      tx_idle = 1'b1;
   endtask

   initial begin
      fill_sine_lut();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_count();
      test_field_extremes();
      test_angles();
      test_count_limits();
      test_output_hold_off();
      test_random_segments(345);
      $display("Sent %0d segments over %0d sample-count writes, checked %0d points.",
               segments_sent, csr_writes, points_checked);
      $display("Covered field extremes, quadrant folds, count clamping and backpressure.");
      if (fail_count == 0 && pending_points.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
